>>> sv/nptm_pkg.sv
// ----------------------------------------------------------------------------
// nptm_pkg
// shared types, constants and helpers of the nand plane timing model
// ----------------------------------------------------------------------------
`default_nettype none

package nptm_pkg;

	// plane array geometry
	localparam int MAX_CHANNELS = 8;
	localparam int MAX_LUNS     = 8;
	localparam int MAX_PLANES   = 4;
	localparam int PLANE_COUNT  = MAX_CHANNELS * MAX_LUNS * MAX_PLANES;
	localparam int ADDR_W       = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

	// walk counter index widths and count widths
	localparam int CH_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int LU_IW = (MAX_LUNS > 1) ? $clog2(MAX_LUNS) : 1;
	localparam int PL_IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int CH_CW = $clog2(MAX_CHANNELS + 1);
	localparam int LU_CW = $clog2(MAX_LUNS + 1);
	localparam int PL_CW = $clog2(MAX_PLANES + 1);

	// field widths
	localparam int OP_W    = 2;
	localparam int CHAN_W  = 3;
	localparam int LUN_W   = 3;
	localparam int PLANE_W = 2;
	localparam int TIME_W  = 62;
	localparam int DELAY_W = 32;
	localparam int CHU_W   = 4;
	localparam int LUU_W   = 4;
	localparam int PLU_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// stream packing
	localparam int IN_BITS     = CHAN_W + LUN_W + PLANE_W + 2 * TIME_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((TIME_W + 7) / 8) * 8;
	localparam int OFS_CHAN    = 0;
	localparam int OFS_LUN     = OFS_CHAN + CHAN_W;
	localparam int OFS_PLANE   = OFS_LUN + LUN_W;
	localparam int OFS_START   = OFS_PLANE + PLANE_W;
	localparam int OFS_NOW     = OFS_START + TIME_W;

	// command codes
	localparam logic [OP_W-1:0] OP_READ       = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE      = 2'd1;
	localparam logic [OP_W-1:0] OP_ERASE      = 2'd2;
	localparam logic [OP_W-1:0] OP_ZONE_ERASE = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_READ_DELAY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_DELAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_DELAY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LUNS        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANES      = 3'd5;

	// register reset values
	localparam logic [DELAY_W-1:0] RST_READ_DELAY  = 32'd40000;
	localparam logic [DELAY_W-1:0] RST_WRITE_DELAY = 32'd200000;
	localparam logic [DELAY_W-1:0] RST_ERASE_DELAY = 32'd2000000;
	localparam logic [CHU_W-1:0]   RST_CHANNELS    = 4'd8;
	localparam logic [LUU_W-1:0]   RST_LUNS        = 4'd8;
	localparam logic [PLU_W-1:0]   RST_PLANES      = 3'd1;

	// shared arithmetic unit operations
	typedef enum logic [1:0] {
		UOP_MAX    = 2'd0,
		UOP_ADDSAT = 2'd1,
		UOP_SUB    = 2'd2
	} uop_t;

	typedef struct packed {
		uop_t              uop;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic              re;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] wdata;
	} ram_req_t;

	// flat plane index from channel, lun and plane
	function automatic logic [ADDR_W-1:0] plane_addr(input int ch, input int lu, input int pl);
		int idx;
		idx = ((ch % MAX_CHANNELS) * MAX_LUNS + (lu % MAX_LUNS)) * MAX_PLANES
			+ (pl % MAX_PLANES);
		return ADDR_W'(idx);
	endfunction

endpackage

`default_nettype wire

>>> sv/nptm_ram.sv
// ----------------------------------------------------------------------------
// nptm_ram
// generic single-port-write, registered-read memory
// ----------------------------------------------------------------------------
`default_nettype none

module nptm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/nptm_unit.sv
// ----------------------------------------------------------------------------
// nptm_unit
// shared time arithmetic: maximum, saturating add, subtract
// ----------------------------------------------------------------------------
`default_nettype none

module nptm_unit
	import nptm_pkg::*;
(
	input  wire unit_req_t         req,
	output logic [TIME_W-1:0]      y
);

	logic [TIME_W:0] sum;

	assign sum = {1'b0, req.a} + {1'b0, req.b};

	always_comb begin
		case (req.uop)
			UOP_MAX:    y = (req.a > req.b) ? req.a : req.b;
			UOP_ADDSAT: y = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
			UOP_SUB:    y = req.a - req.b;
			default:    y = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/nptm_seq.sv
// ----------------------------------------------------------------------------
// nptm_seq
// command sequencer: plane walk, free-time update, result register
// ----------------------------------------------------------------------------
`default_nettype none

module nptm_seq
	import nptm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command item
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [OP_W-1:0]       operation,
	input  wire logic [CHAN_W-1:0]     channel,
	input  wire logic [LUN_W-1:0]      lun,
	input  wire logic [PLANE_W-1:0]    plane,
	input  wire logic [TIME_W-1:0]     start_time,
	input  wire logic [TIME_W-1:0]     now_time,
	// configuration
	input  wire logic [DELAY_W-1:0]    read_delay_ns,
	input  wire logic [DELAY_W-1:0]    write_delay_ns,
	input  wire logic [DELAY_W-1:0]    erase_delay_ns,
	input  wire logic [CHU_W-1:0]      channels_used,
	input  wire logic [LUU_W-1:0]      luns_used,
	input  wire logic [PLU_W-1:0]      planes_used,
	// result item
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [TIME_W-1:0]          latency_ns,
	// free-time store
	output ram_req_t                   ram_req,
	input  wire logic [TIME_W-1:0]     ram_rdata,
	input  wire logic                  ram_rvld,
	// shared unit
	output unit_req_t                  unit_req,
	input  wire logic [TIME_W-1:0]     unit_y
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_BEG  = 6'b000100,
		ST_ADD  = 6'b001000,
		ST_MAX  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t             state_q;
	logic               zone_q;
	logic [TIME_W-1:0]  start_q;
	logic [DELAY_W-1:0] delay_q;
	logic [TIME_W-1:0]  acc_q;
	logic [TIME_W-1:0]  maxd_q;
	logic [CH_IW-1:0]   c_q;
	logic [LU_IW-1:0]   l_q;
	logic [PL_IW-1:0]   p_q;
	logic [CH_CW-1:0]   nc_q;
	logic [LU_CW-1:0]   nl_q;
	logic [PL_CW-1:0]   np_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               out_vld_q;
	logic [TIME_W-1:0]  out_q;

	logic [CH_CW-1:0]   nc;
	logic [LU_CW-1:0]   nl;
	logic [PL_CW-1:0]   np;
	logic               c_last, l_last, p_last, last;
	logic [CH_IW-1:0]   c_nx;
	logic [LU_IW-1:0]   l_nx;
	logic [PL_IW-1:0]   p_nx;
	logic [DELAY_W-1:0] delay_sel;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_vld_q;
	assign latency_ns = out_q;

	// zone counts clamped to the plane array
	assign nc = (int'(channels_used) > MAX_CHANNELS) ? CH_CW'(MAX_CHANNELS)
		: CH_CW'(channels_used);
	assign nl = (int'(luns_used) > MAX_LUNS) ? LU_CW'(MAX_LUNS) : LU_CW'(luns_used);
	assign np = (int'(planes_used) > MAX_PLANES) ? PL_CW'(MAX_PLANES)
		: PL_CW'(planes_used);

	always_comb begin
		case (operation)
			OP_READ:  delay_sel = read_delay_ns;
			OP_WRITE: delay_sel = write_delay_ns;
			default:  delay_sel = erase_delay_ns;
		endcase
	end

	// walk position
	assign c_last = (CH_CW'(c_q) + CH_CW'(1)) == nc_q;
	assign l_last = (LU_CW'(l_q) + LU_CW'(1)) == nl_q;
	assign p_last = (PL_CW'(p_q) + PL_CW'(1)) == np_q;
	assign last   = !zone_q || (c_last && l_last && p_last);

	always_comb begin
		c_nx = c_q;
		l_nx = l_q;
		p_nx = p_q;
		if (!p_last) begin
			p_nx = p_q + PL_IW'(1);
		end else begin
			p_nx = '0;
			if (!l_last) begin
				l_nx = l_q + LU_IW'(1);
			end else begin
				l_nx = '0;
				c_nx = c_q + CH_IW'(1);
			end
		end
	end

	// memory access
	always_comb begin
		ram_req.re    = (state_q == ST_RD);
		ram_req.we    = (state_q == ST_MAX);
		ram_req.addr  = addr_q;
		ram_req.wdata = acc_q;
	end

	// operand selection for the shared unit
	always_comb begin
		unit_req.uop = UOP_MAX;
		unit_req.a   = '0;
		unit_req.b   = '0;
		case (state_q)
			ST_BEG: begin
				unit_req.uop = UOP_MAX;
				unit_req.a   = ram_rvld ? ram_rdata : '0;
				unit_req.b   = start_q;
			end
			ST_ADD: begin
				unit_req.uop = UOP_ADDSAT;
				unit_req.a   = acc_q;
				unit_req.b   = TIME_W'(delay_q);
			end
			ST_MAX: begin
				unit_req.uop = UOP_MAX;
				unit_req.a   = maxd_q;
				unit_req.b   = acc_q;
			end
			ST_FIN: begin
				unit_req.uop = UOP_SUB;
				unit_req.a   = maxd_q;
				unit_req.b   = start_q;
			end
			default: begin
				unit_req.uop = UOP_MAX;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			// in the final state the result register is either reloaded or kept
			if (out_vld_q && out_ready && state_q != ST_FIN) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (operation == OP_ZONE_ERASE
							&& (nc == '0 || nl == '0 || np == '0)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD:  state_q <= ST_BEG;
				ST_BEG: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_MAX;
				ST_MAX: state_q <= last ? ST_FIN : ST_RD;
				ST_FIN: begin
					if (!out_vld_q || out_ready) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					zone_q  <= (operation == OP_ZONE_ERASE);
					start_q <= (start_time != '0) ? start_time : now_time;
					maxd_q  <= (start_time != '0) ? start_time : now_time;
					delay_q <= delay_sel;
					nc_q    <= nc;
					nl_q    <= nl;
					np_q    <= np;
					c_q     <= '0;
					l_q     <= '0;
					p_q     <= '0;
					if (operation == OP_ZONE_ERASE) begin
						addr_q <= '0;
					end else begin
						addr_q <= plane_addr(int'(channel), int'(lun), int'(plane));
					end
				end
			end
			ST_BEG: acc_q <= unit_y;
			ST_ADD: acc_q <= unit_y;
			ST_MAX: begin
				maxd_q <= unit_y;
				c_q    <= c_nx;
				l_q    <= l_nx;
				p_q    <= p_nx;
				addr_q <= plane_addr(int'(c_nx), int'(l_nx), int'(p_nx));
			end
			ST_FIN: begin
				if (!out_vld_q || out_ready) begin
					out_q <= unit_y;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sv/nand_plane_timing_model.sv
// ----------------------------------------------------------------------------
// nand_plane_timing_model
// busy-until time per flash plane and command completion latency
// ----------------------------------------------------------------------------
// Each command item names a read, write or erase on one plane (channel, lun,
// plane) or a zone erase over the first channels_used x luns_used x
// planes_used planes. The start time is start_time, or now_time when
// start_time is zero. Each touched plane begins service at the later of the
// start time and its free time, and becomes free after the configured delay
// (saturating at 2^62-1); the result item carries the largest new free time
// minus the start time, zero if a zone erase touches no plane. A command
// holds the input from its accept through the read, begin, add and max
// states (read-modify-write) and the final state that loads the result; a
// zone erase repeats the read-modify-write per plane, or goes straight to
// the final state when it touches no plane. Each read-modify-write of the
// free-time memory (registered read) passes three times through one shared
// 62-bit max / saturating-add / subtract unit. The next command is accepted
// while a result still waits in the output register; the final state of that
// next command then waits until the result is taken. The free-time store
// resets to zero through one valid flip-flop per plane, so no clearing pass
// is needed. Configuration writes are always ready; the user must make them
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module nand_plane_timing_model
	import nptm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// command items
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [IN_TDATA_W-1:0]    s_tdata,   // channel, lun, plane, start_time, now_time
	input  wire logic [OP_W-1:0]          s_tuser,   // operation
	// result items
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [OUT_TDATA_W-1:0]        m_tdata,   // latency_ns
	// register writes
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	// configuration registers
	logic [DELAY_W-1:0] read_delay_q;
	logic [DELAY_W-1:0] write_delay_q;
	logic [DELAY_W-1:0] erase_delay_q;
	logic [CHU_W-1:0]   channels_used_q;
	logic [LUU_W-1:0]   luns_used_q;
	logic [PLU_W-1:0]   planes_used_q;

	// one valid bit per plane: an unwritten plane reads as free at time zero
	logic [PLANE_COUNT-1:0] vld_q;

	ram_req_t          ram_req;
	logic [TIME_W-1:0] ram_rdata;
	unit_req_t         unit_req;
	logic [TIME_W-1:0] unit_y;
	logic [TIME_W-1:0] latency_ns;

	assign cfg_ready = 1'b1;
	assign m_tdata   = OUT_TDATA_W'(latency_ns);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_delay_q    <= RST_READ_DELAY;
			write_delay_q   <= RST_WRITE_DELAY;
			erase_delay_q   <= RST_ERASE_DELAY;
			channels_used_q <= RST_CHANNELS;
			luns_used_q     <= RST_LUNS;
			planes_used_q   <= RST_PLANES;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_READ_DELAY:  read_delay_q    <= cfg_data[DELAY_W-1:0];
				REG_WRITE_DELAY: write_delay_q   <= cfg_data[DELAY_W-1:0];
				REG_ERASE_DELAY: erase_delay_q   <= cfg_data[DELAY_W-1:0];
				REG_CHANNELS:    channels_used_q <= cfg_data[CHU_W-1:0];
				REG_LUNS:        luns_used_q     <= cfg_data[LUU_W-1:0];
				REG_PLANES:      planes_used_q   <= cfg_data[PLU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// mark a plane valid once its free time has been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_req.we) begin
			vld_q[ram_req.addr] <= 1'b1;
		end
	end

	nptm_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.operation      (s_tuser),
		.channel        (s_tdata[OFS_CHAN +: CHAN_W]),
		.lun            (s_tdata[OFS_LUN +: LUN_W]),
		.plane          (s_tdata[OFS_PLANE +: PLANE_W]),
		.start_time     (s_tdata[OFS_START +: TIME_W]),
		.now_time       (s_tdata[OFS_NOW +: TIME_W]),
		.read_delay_ns  (read_delay_q),
		.write_delay_ns (write_delay_q),
		.erase_delay_ns (erase_delay_q),
		.channels_used  (channels_used_q),
		.luns_used      (luns_used_q),
		.planes_used    (planes_used_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.latency_ns     (latency_ns),
		.ram_req        (ram_req),
		.ram_rdata      (ram_rdata),
		.ram_rvld       (vld_q[ram_req.addr]),
		.unit_req       (unit_req),
		.unit_y         (unit_y)
	);

	// plane free-time store
	nptm_ram #(
		.WIDTH (TIME_W),
		.DEPTH (PLANE_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.addr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.addr),
		.rdata (ram_rdata)
	);

	// shared max / saturating add / subtract unit
	nptm_unit u_unit (
		.req (unit_req),
		.y   (unit_y)
	);

endmodule

`default_nettype wire
